// File: rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, character codes and helpers of the adapter response parser.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int MaxLineBytes = 8;
  localparam int VersionChars = 5;

  localparam int ByteIdxW  = $clog2(MaxLineBytes + 1);
  localparam int LineIdxW  = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1;
  localparam int VerCntW   = $clog2(VersionChars + 1);
  localparam int PacketW   = 64;
  localparam int VerTextW  = 40;
  localparam int IdW       = 29;
  localparam int CfgDataW  = 29;
  localparam int CfgIdxW   = 1;

  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharPrompt = 8'h3E;  // '>'
  localparam logic [7:0] CharOk     = 8'h4F;  // 'O'
  localparam logic [7:0] CharEcho   = 8'h45;  // 'E'
  localparam logic [7:0] CharFail   = 8'h3F;  // '?'
  localparam logic [7:0] CharVer    = 8'h76;  // 'v'
  localparam logic [7:0] CharDot    = 8'h2E;  // '.'
  localparam logic [7:0] CharSpace  = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 1'b0,
    REG_ID   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_DATA = 2'd2
  } mode_e;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_DONE   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FAIL    = 2'd1,
    STATUS_PENDING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    VPH_SEEK  = 2'd0,
    VPH_MAJOR = 2'd1,
    VPH_MINOR = 2'd2
  } ver_phase_e;

  typedef struct packed {
    logic                result_kind;
    logic [IdW-1:0]      packet_id;
    logic [3:0]          byte_count;
    logic [PacketW-1:0]  packet_bytes;
    logic [1:0]          response_status;
    logic [VerTextW-1:0] version_text;
    logic [2:0]          version_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } step_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// File: rtl/arp_if.sv
// ----------------------------------------------------------------------------
// arp_if
// Valid/ready channels of the parser: received characters and results.
// ----------------------------------------------------------------------------
interface arp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface arp_result_if import arp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [IdW-1:0]      packet_id;
  logic [3:0]          byte_count;
  logic [PacketW-1:0]  packet_bytes;
  logic [1:0]          response_status;
  logic [VerTextW-1:0] version_text;
  logic [2:0]          version_length;

  modport source (output valid, output result_kind, output packet_id, output byte_count,
                  output packet_bytes, output response_status, output version_text,
                  output version_length, input ready);
  modport sink   (input valid, input result_kind, input packet_id, input byte_count,
                  input packet_bytes, input response_status, input version_text,
                  input version_length, output ready);
endinterface

// File: rtl/arp_parse_core.sv
// ----------------------------------------------------------------------------
// arp_parse_core
// Parser state and the next-state update for one character.
// ----------------------------------------------------------------------------
module arp_parse_core import arp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_en_i,
  input  logic [7:0]     char_i,
  input  logic [1:0]     mode_i,
  input  logic [IdW-1:0] id_i,
  output step_t          step_o
);

  logic                line_start_q, line_start_d;
  logic                expect_hi_q, expect_hi_d;
  logic                in_ver_line_q, in_ver_line_d;
  logic                line_has_data_q, line_has_data_d;
  logic                reply_good_q, reply_good_d;
  logic [ByteIdxW-1:0] byte_idx_q, byte_idx_d;
  ver_phase_e          ver_phase_q, ver_phase_d;
  logic [VerCntW-1:0]  ver_cnt_q, ver_cnt_d;

  logic [7:0] line_bytes_q [MaxLineBytes];
  logic [7:0] line_bytes_d [MaxLineBytes];
  logic [7:0] ver_store_q  [VersionChars];
  logic [7:0] ver_store_d  [VersionChars];

  logic [4:0]          hex;
  logic                ver_put;
  logic [PacketW-1:0]  pkt_bytes;
  logic [VerTextW-1:0] ver_text;
  logic [1:0]          status;
  logic                is_prompt, is_eol;

  assign hex       = hex_nibble(char_i);
  assign is_prompt = (char_i == CharPrompt);
  assign is_eol    = (char_i == CharCr) || (char_i == CharLf);

  // Result payload: only bytes below the fill counts are shown
  always_comb begin
    pkt_bytes = '0;
    for (int i = 0; i < MaxLineBytes; i++) begin
      if (ByteIdxW'(i) < byte_idx_q) pkt_bytes[8*i +: 8] = line_bytes_q[i];
    end
    ver_text = '0;
    for (int i = 0; i < VersionChars; i++) begin
      if (VerCntW'(i) < ver_cnt_q) ver_text[8*i +: 8] = ver_store_q[i];
    end
    case (mode_i)
      MODE_CMD:  status = reply_good_q ? STATUS_OK : STATUS_FAIL;
      MODE_DATA: status = reply_good_q ? STATUS_PENDING : STATUS_FAIL;
      default:   status = STATUS_PENDING;
    endcase
  end

  always_comb begin
    step_o.valid = step_en_i && (is_prompt || (is_eol && line_has_data_q));
    step_o.res.version_text   = ver_text;
    step_o.res.version_length = 3'(ver_cnt_q);
    if (is_prompt) begin
      step_o.res.result_kind     = KIND_DONE;
      step_o.res.packet_id       = '0;
      step_o.res.byte_count      = '0;
      step_o.res.packet_bytes    = '0;
      step_o.res.response_status = status;
    end else begin
      step_o.res.result_kind     = KIND_PACKET;
      step_o.res.packet_id       = id_i;
      step_o.res.byte_count      = 4'(byte_idx_q);
      step_o.res.packet_bytes    = pkt_bytes;
      step_o.res.response_status = STATUS_PENDING;
    end
  end

  // Next state
  always_comb begin
    line_start_d    = line_start_q;
    expect_hi_d     = expect_hi_q;
    in_ver_line_d   = in_ver_line_q;
    line_has_data_d = line_has_data_q;
    reply_good_d    = reply_good_q;
    byte_idx_d      = byte_idx_q;
    ver_phase_d     = ver_phase_q;
    ver_cnt_d       = ver_cnt_q;
    line_bytes_d    = line_bytes_q;
    ver_store_d     = ver_store_q;
    ver_put         = 1'b0;

    if (step_en_i) begin
      if (is_prompt || is_eol) begin
        line_start_d    = 1'b1;
        expect_hi_d     = 1'b1;
        in_ver_line_d   = 1'b0;
        line_has_data_d = 1'b0;
        byte_idx_d      = '0;
        if (is_prompt) reply_good_d = 1'b0;
      end else begin
        line_start_d = 1'b0;
        case (mode_i)
          MODE_CMD: begin
            if (line_start_q) begin
              if (char_i == CharOk || char_i == CharEcho) begin
                reply_good_d = 1'b1;
                if (char_i == CharEcho) begin
                  in_ver_line_d = 1'b1;
                  ver_phase_d   = VPH_SEEK;
                  ver_cnt_d     = '0;
                end
              end else if (char_i == CharFail) begin
                reply_good_d = 1'b0;
              end
            end else if (in_ver_line_q) begin
              case (ver_phase_q)
                VPH_SEEK: begin
                  if (char_i == CharVer) ver_phase_d = VPH_MAJOR;
                end
                VPH_MAJOR: begin
                  if (is_digit(char_i)) begin
                    ver_put = 1'b1;
                  end else if (char_i == CharDot) begin
                    ver_put     = 1'b1;
                    ver_phase_d = VPH_MINOR;
                  end
                end
                VPH_MINOR: ver_put = is_digit(char_i);
                default: ;
              endcase
            end
          end
          MODE_DATA: begin
            if (hex[4]) begin
              if (line_start_q) begin
                line_has_data_d = 1'b1;
                reply_good_d    = 1'b1;
              end
              if (byte_idx_q < ByteIdxW'(MaxLineBytes)) begin
                for (int i = 0; i < MaxLineBytes; i++) begin
                  if (LineIdxW'(i) == byte_idx_q[LineIdxW-1:0]) begin
                    line_bytes_d[i] = expect_hi_q ? {4'd0, hex[3:0]}
                                                  : {line_bytes_q[i][3:0], hex[3:0]};
                  end
                end
                if (!expect_hi_q) byte_idx_d = byte_idx_q + 1'b1;
                expect_hi_d = !expect_hi_q;
              end
            end else if (char_i == CharSpace) begin
              // close a lone nibble
              if (!expect_hi_q) begin
                byte_idx_d  = byte_idx_q + 1'b1;
                expect_hi_d = 1'b1;
              end
            end else if (line_start_q) begin
              reply_good_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end

    if (ver_put && ver_cnt_q < VerCntW'(VersionChars)) begin
      for (int i = 0; i < VersionChars; i++) begin
        if (VerCntW'(i) == ver_cnt_q) ver_store_d[i] = char_i;
      end
      ver_cnt_d = ver_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q    <= 1'b1;
      expect_hi_q     <= 1'b1;
      in_ver_line_q   <= 1'b0;
      line_has_data_q <= 1'b0;
      reply_good_q    <= 1'b0;
      byte_idx_q      <= '0;
      ver_phase_q     <= VPH_SEEK;
      ver_cnt_q       <= '0;
    end else begin
      line_start_q    <= line_start_d;
      expect_hi_q     <= expect_hi_d;
      in_ver_line_q   <= in_ver_line_d;
      line_has_data_q <= line_has_data_d;
      reply_good_q    <= reply_good_d;
      byte_idx_q      <= byte_idx_d;
      ver_phase_q     <= ver_phase_d;
      ver_cnt_q       <= ver_cnt_d;
    end
  end

  // Stores are read only below their fill counts
  always_ff @(posedge clk_i) begin
    line_bytes_q <= line_bytes_d;
    ver_store_q  <= ver_store_d;
  end

endmodule

// File: rtl/adapter_response_parser.sv
// ----------------------------------------------------------------------------
// adapter_response_parser
// Character-stream parser of an adapter reply with packet and status output.
// ----------------------------------------------------------------------------
// Takes one reply character per beat and returns a data packet at each line
// end that carried hex data, and a status beat at every '>' prompt. A
// character is held in an input register; once the result register is free
// or being taken, the parse core updates its state from it and loads the
// result register, where the result stays valid until it is taken. One
// character per clock is sustained while the result side is ready. While a
// result waits in the result register, a character in the input register
// is held there and the input stalls. Write response_mode and response_id
// only while no character is in flight.
module adapter_response_parser import arp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  arp_char_if.sink            rx_if,
  arp_result_if.source        res_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic           in_valid_q;
  logic [7:0]     in_char_q;
  logic [1:0]     mode_q;
  logic [IdW-1:0] id_q;
  logic           out_valid_q, out_valid_d;
  result_t        out_q;
  logic           fire;
  step_t          step;

  assign fire        = in_valid_q && (!out_valid_q || res_if.ready);
  assign rx_if.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      id_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE: mode_q <= cfg_data_i[1:0];
        REG_ID:   id_q   <= cfg_data_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_if.ready) begin
      in_valid_q <= rx_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_if.valid && rx_if.ready) in_char_q <= rx_if.rx_char;
  end

  arp_parse_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (fire),
    .char_i    (in_char_q),
    .mode_i    (mode_q),
    .id_i      (id_q),
    .step_o    (step)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) out_valid_d = step.valid;
    else if (res_if.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step.valid) out_q <= step.res;
  end

  assign res_if.valid           = out_valid_q;
  assign res_if.result_kind     = out_q.result_kind;
  assign res_if.packet_id       = out_q.packet_id;
  assign res_if.byte_count      = out_q.byte_count;
  assign res_if.packet_bytes    = out_q.packet_bytes;
  assign res_if.response_status = out_q.response_status;
  assign res_if.version_text    = out_q.version_text;
  assign res_if.version_length  = out_q.version_length;

`ifndef SYNTHESIS
  a_prompt_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_char_q == CharPrompt |=> out_valid_q && out_q.result_kind == KIND_DONE)
    else $error("prompt did not produce a status beat");

  a_plain_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_char_q != CharPrompt && in_char_q != CharCr && in_char_q != CharLf
    |=> !out_valid_q)
    else $error("result produced for a character inside a line");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.byte_count <= 4'(MaxLineBytes)
                    && out_q.version_length <= 3'(VersionChars))
    else $error("packet or version count out of range");
`endif

endmodule

// File: bench/adapter_response_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adapter_response_parser_tb
// Self-checking bench of the adapter reply parser.
// ----------------------------------------------------------------------------
// Streams reply characters into the parser under several mode and id
// settings. Each accepted character runs through a local parse model that
// queues the packet or prompt status it should produce. Result beats are
// compared field by field against that queue. Both channels idle at random,
// and in one phase the result side holds off long enough to back up the
// input. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module adapter_response_parser_tb;
  import arp_pkg::*;

  localparam int          ClkHalf       = 5;
  localparam int          ResetCycles   = 4;
  localparam int          DrainCycles   = 4;
  localparam int          TailCycles    = 8;
  localparam int          HoldCycles    = 400;
  localparam int          StallLimit    = 3000;
  localparam int          NumPhases     = 12;
  localparam int          PressurePhase = 3;
  localparam int          ActiveBudget  = 220;
  localparam int          IdleBudget    = 80;
  localparam logic [1:0]  ModeSpare     = 2'd3;

  logic clk    = 1'b0;
  logic rst_ni = 1'b0;

  logic                rx_valid  = 1'b0;
  logic [7:0]          rx_char   = 8'h00;
  logic                res_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  arp_char_if   rx_if ();
  arp_result_if res_if ();

  assign rx_if.valid   = rx_valid;
  assign rx_if.rx_char = rx_char;
  assign res_if.ready  = res_ready;

  adapter_response_parser u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .rx_if      (rx_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  logic [7:0] reply_chars [$];
  result_t    expected_results [$];
  int         mismatches = 0;

  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;

  logic [1:0] phase_mode [NumPhases] = '{MODE_CMD, MODE_DATA, MODE_IDLE, MODE_DATA,
                                         MODE_CMD, ModeSpare, MODE_DATA, MODE_CMD,
                                         MODE_DATA, MODE_IDLE, MODE_DATA, MODE_CMD};

  // Parser model: configuration and line state
  logic [1:0]     cfg_mode = MODE_IDLE;
  logic [IdW-1:0] cfg_id   = '0;

  bit         line_start = 1'b1;
  bit         high_nib   = 1'b1;
  bit         in_ver     = 1'b0;
  bit         has_data   = 1'b0;
  bit         reply_good = 1'b0;
  logic [3:0] byte_idx   = 4'd0;
  logic [7:0] line_bytes [MaxLineBytes];
  ver_phase_e ver_phase  = VPH_SEEK;
  logic [2:0] ver_count  = 3'd0;
  logic [7:0] ver_store  [VersionChars];

  function automatic void restart_line();
    line_start = 1'b1;
    high_nib   = 1'b1;
    in_ver     = 1'b0;
    has_data   = 1'b0;
    byte_idx   = 4'd0;
  endfunction

  function automatic logic [VerTextW-1:0] version_word();
    logic [VerTextW-1:0] w;
    w = '0;
    for (int i = 0; i < VersionChars; i++)
      if (i < ver_count) w[8*i +: 8] = ver_store[i];
    return w;
  endfunction

  function automatic void store_ver_char(input logic [7:0] c);
    if (ver_count < VersionChars) begin
      ver_store[ver_count] = c;
      ver_count = ver_count + 3'd1;
    end
  endfunction

  // Advance the model by one character; returns 1 when a result beat is due.
  function automatic bit parse_char(input logic [7:0] c, output result_t r);
    logic [3:0] nib;
    bit         is_hex;
    bit         digit;
    bit         produced;
    r        = '0;
    produced = 1'b0;
    digit    = (c >= "0") && (c <= "9");
    is_hex   = 1'b1;
    if (digit) nib = c[3:0];
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) nib = c[3:0] + 4'd9;
    else begin
      nib    = 4'd0;
      is_hex = 1'b0;
    end

    if (c == CharPrompt) begin
      r.result_kind = KIND_DONE;
      if (cfg_mode == MODE_CMD) r.response_status = reply_good ? STATUS_OK : STATUS_FAIL;
      else if (cfg_mode == MODE_DATA) r.response_status = reply_good ? STATUS_PENDING : STATUS_FAIL;
      else r.response_status = STATUS_PENDING;
      r.version_text   = version_word();
      r.version_length = ver_count;
      restart_line();
      reply_good = 1'b0;
      return 1'b1;
    end

    if (c == CharCr || c == CharLf) begin
      if (has_data) begin
        r.result_kind = KIND_PACKET;
        r.packet_id   = cfg_id;
        r.byte_count  = byte_idx;
        for (int i = 0; i < MaxLineBytes; i++)
          if (i < byte_idx) r.packet_bytes[8*i +: 8] = line_bytes[i];
        r.response_status = STATUS_PENDING;
        r.version_text    = version_word();
        r.version_length  = ver_count;
        produced = 1'b1;
      end
      restart_line();
      return produced;
    end

    if (cfg_mode == MODE_CMD) begin
      if (line_start) begin
        if (c == CharOk || c == CharEcho) begin
          reply_good = 1'b1;
          if (c == CharEcho) begin
            in_ver    = 1'b1;
            ver_phase = VPH_SEEK;
            ver_count = 3'd0;
          end
        end else if (c == CharFail) begin
          reply_good = 1'b0;
        end
      end else if (in_ver) begin
        case (ver_phase)
          VPH_SEEK: if (c == CharVer) ver_phase = VPH_MAJOR;
          VPH_MAJOR: begin
            if (digit) store_ver_char(c);
            else if (c == CharDot) begin
              store_ver_char(c);
              ver_phase = VPH_MINOR;
            end
          end
          VPH_MINOR: if (digit) store_ver_char(c);
          default: ;
        endcase
      end
    end else if (cfg_mode == MODE_DATA) begin
      if (is_hex) begin
        if (line_start) begin
          has_data   = 1'b1;
          reply_good = 1'b1;
        end
        // drop digits once the line is full
        if (byte_idx < MaxLineBytes) begin
          if (high_nib) begin
            line_bytes[byte_idx] = {4'h0, nib};
            high_nib = 1'b0;
          end else begin
            line_bytes[byte_idx] = {line_bytes[byte_idx][3:0], nib};
            byte_idx = byte_idx + 4'd1;
            high_nib = 1'b1;
          end
        end
      end else if (c == CharSpace) begin
        // close a lone nibble
        if (!high_nib) begin
          byte_idx = byte_idx + 4'd1;
          high_nib = 1'b1;
        end
      end else if (line_start) begin
        reply_good = 1'b0;
      end
    end

    line_start = 1'b0;
    return 1'b0;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + {4'h0, v};
  endfunction

  task automatic push_char(input logic [7:0] c);
    reply_chars.push_back(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_chars.push_back(s[i]);
  endtask

  task automatic push_line_end();
    case ($urandom_range(0, 2))
      0: push_char(CharCr);
      1: push_char(CharLf);
      default: begin
        push_char(CharCr);
        push_char(CharLf);
      end
    endcase
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == REG_MODE) cfg_mode = val[1:0];
    else cfg_id = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every character is in and every result is out, then let the
  // pipeline settle in case the last character produced nothing.
  task automatic wait_drained();
    do @(negedge clk);
    while (reply_chars.size() != 0 || rx_valid || expected_results.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Character driver
  int tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_ni) begin
      rx_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!rx_valid || rx_if.ready) begin
      if (tx_gap > 0) begin
        rx_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (reply_chars.size() > 0) begin
        rx_char  <= reply_chars.pop_front();
        rx_valid <= 1'b1;
        tx_gap   <= pick_gap(quiet_tx);
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Run the model on every accepted character
  always @(posedge clk) begin
    result_t due;
    if (rst_ni && rx_valid && rx_if.ready)
      if (parse_char(rx_char, due)) expected_results.push_back(due);
  end

  // Result-side ready with random stalls and one long hold-off
  int stall_left = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HoldCycles;
      res_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else begin
      res_ready  <= 1'b1;
      stall_left <= pick_gap(quiet_rx);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_ni && res_if.valid && res_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 64'(want.result_kind), 64'(res_if.result_kind));
        check_field("packet_id", 64'(want.packet_id), 64'(res_if.packet_id));
        check_field("byte_count", 64'(want.byte_count), 64'(res_if.byte_count));
        check_field("packet_bytes", want.packet_bytes, res_if.packet_bytes);
        check_field("response_status", 64'(want.response_status),
                    64'(res_if.response_status));
        check_field("version_text", 64'(want.version_text), 64'(res_if.version_text));
        check_field("version_length", 64'(want.version_length),
                    64'(res_if.version_length));
      end
    end
  end

  // Watchdog on cycles without any beat
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((rx_valid && rx_if.ready) || (res_if.valid && res_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int                  r;
    int                  n;
    int                  hex_w;
    int                  budget;
    logic [1:0]          m;
    logic [CfgDataW-1:0] id;

    repeat (ResetCycles) @(posedge clk);
    rst_ni <= 1'b1;

    // Directed: command replies, version overflow, failure
    write_reg(REG_MODE, MODE_CMD);
    write_reg(REG_ID, '0);
    @(negedge clk);
    push_text("Ev1.2345");
    push_char(CharCr);
    push_char(CharPrompt);
    push_char(CharFail);
    push_char(CharPrompt);
    wait_drained();

    // Directed: hex pairs, lone nibble, non-hex start, data dropped at prompt
    write_reg(REG_MODE, MODE_DATA);
    write_reg(REG_ID, '1);
    @(negedge clk);
    push_text("00Ff7 ");
    push_char(CharLf);
    push_char(8'hFF);
    push_char(CharPrompt);
    push_text("12");
    push_char(CharPrompt);
    wait_drained();

    // Directed: undefined mode behaves as idle
    write_reg(REG_MODE, ModeSpare);
    write_reg(REG_ID, CfgDataW'($urandom));
    @(negedge clk);
    push_char(8'h00);
    push_char(CharPrompt);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      m        = phase_mode[p];
      quiet_tx = (p == 6 || p == 11 || p == PressurePhase);
      quiet_rx = (p == 6 || p == 11);
      if (p == 0) id = '0;
      else if (p == 1) id = '1;
      else id = CfgDataW'($urandom);
      write_reg(REG_MODE, m);
      write_reg(REG_ID, id);
      @(negedge clk);
      if (p == PressurePhase) hold_requests++;
      budget = (m == MODE_CMD || m == MODE_DATA) ? ActiveBudget : IdleBudget;
      if (m == MODE_DATA) hex_w = 85;
      else if (m == MODE_CMD) hex_w = 12;
      else hex_w = 40;

      while (reply_chars.size() < budget) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          repeat ($urandom_range(1, 6)) push_char(8'($urandom));
        end else if (r < 32) begin
          push_char(CharPrompt);
        end else begin
          r = $urandom_range(0, 99);
          if (r < hex_w) begin
            // hex data line, sometimes malformed
            if ($urandom_range(0, 9) == 0) push_char(CharSpace);
            if ($urandom_range(0, 99) < 85) n = $urandom_range(0, MaxLineBytes);
            else n = $urandom_range(MaxLineBytes + 1, MaxLineBytes + 3);
            repeat (n) begin
              push_char(hex_char(4'($urandom)));
              if ($urandom_range(0, 9) == 0) push_char(CharSpace);
              else begin
                push_char(hex_char(4'($urandom)));
                if ($urandom_range(0, 3) == 0) push_char(CharSpace);
              end
            end
            if ($urandom_range(0, 7) == 0) push_char(hex_char(4'($urandom)));
            if ($urandom_range(0, 9) != 0) push_line_end();
          end else if (r < hex_w + (100 - hex_w) / 2) begin
            case ($urandom_range(0, 2))
              0: push_text("OK");
              1: push_char(CharFail);
              default: repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(8'h41, 8'h5A)));
            endcase
            push_line_end();
          end else begin
            // echo line carrying a version
            push_char(CharEcho);
            repeat ($urandom_range(0, 4)) push_char(8'($urandom_range(8'h41, 8'h5A)));
            if ($urandom_range(0, 9) != 0) push_char(CharVer);
            repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(8'h30, 8'h39)));
            if ($urandom_range(0, 6) != 0) push_char(CharDot);
            repeat ($urandom_range(0, 4)) push_char(8'($urandom_range(8'h30, 8'h39)));
            if ($urandom_range(0, 4) == 0) push_text(" x.7");
            push_line_end();
          end
        end
      end
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk);
    if (expected_results.size() != 0)
      $error("%0d expected results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
